// ----- hdl/mrms_pkg.sv -----
// Shared types and constants for the memory region map sanitizer.
package mrms_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int STEP_W      = $clog2(MAX_ENTRIES + 2);
   localparam int INDEX_W     = 7;

   localparam logic [2:0] CMD_CLEAR = 3'd0;
   localparam logic [2:0] CMD_LOAD  = 3'd1;
   localparam logic [2:0] CMD_BUILD = 3'd2;
   localparam logic [2:0] CMD_QUERY = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic [1:0] SEL_HOLD  = 2'd0;
   localparam logic [1:0] SEL_LEFT  = 2'd1;
   localparam logic [1:0] SEL_RIGHT = 2'd2;
   localparam logic [1:0] SEL_EXT   = 2'd3;

   typedef struct packed {
      logic        hole;
      logic [63:0] base;
      logic [63:0] length;
      logic [31:0] rtype;
   } entry_type;

   typedef struct packed {
      logic [1:0] sel;
      logic       mark;
      logic       mark_hole;
   } cell_ctrl_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  entry_count;
      logic [63:0] usable_total;
      logic [63:0] highest_usable;
      logic        region_usable;
      logic        index_valid;
      logic [63:0] out_base;
      logic [63:0] out_length;
      logic [31:0] out_type;
   } rsp_type;

endpackage

// ----- hdl/mrms_cell.sv -----
// One storage cell of the entry chain: holds one map entry, loads from a neighbour or outside.
module mrms_cell import mrms_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     left_in,
   input  entry_type     right_in,
   input  entry_type     ext_in,
   output entry_type     ent_out
);

   entry_type ent_ff;
   entry_type ent_in;

   always_comb begin
      ent_in = ent_ff;
      case (ctrl.sel)
         SEL_LEFT:  ent_in = left_in;
         SEL_RIGHT: ent_in = right_in;
         SEL_EXT:   ent_in = ext_in;
         default:   ent_in = ent_ff;
      endcase
      if (ctrl.mark) begin
         ent_in.hole = ctrl.mark_hole;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent_out = ent_ff;

endmodule

// ----- hdl/mrms_merge.sv -----
// Merge unit: folds sorted entries off the chain head and emits merged entries plus totals.
module mrms_merge import mrms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             run,
   input  logic             init,
   input  entry_type        head_in,
   input  logic             head_valid,
   input  logic [31:0]      usable_type,
   output entry_type        emit,
   output logic [CNT_W-1:0] merged_count,
   output logic [63:0]      total,
   output logic [63:0]      top
);

   entry_type        h_ff, h_in;
   logic [63:0]      h_end_ff, h_end_in;
   logic             hv_ff, hv_in;
   entry_type        acc_ff, acc_in;
   logic [63:0]      acc_end_ff, acc_end_in;
   logic             acc_valid_ff, acc_valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      total_ff, total_in;
   logic [63:0]      top_ff, top_in;
   logic             merge_hit;
   logic             emit_now;

   always_comb begin
      merge_hit = acc_valid_ff && hv_ff && (h_ff.rtype == acc_ff.rtype)
                  && (h_ff.base <= acc_end_ff);
      emit_now  = run && acc_valid_ff && (!hv_ff || !merge_hit);

      h_in         = h_ff;
      h_end_in     = h_end_ff;
      hv_in        = 1'b0;
      acc_in       = acc_ff;
      acc_end_in   = acc_end_ff;
      acc_valid_in = 1'b0;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      top_in       = top_ff;

      if (run) begin
         h_in         = head_in;
         h_end_in     = head_in.base + head_in.length;
         hv_in        = head_valid;
         acc_valid_in = acc_valid_ff;
         if (hv_ff) begin
            acc_valid_in = 1'b1;
            if (merge_hit) begin
               if (h_end_ff > acc_end_ff) begin
                  acc_in.length = h_end_ff - acc_ff.base;
                  acc_end_in    = h_end_ff;
               end
            end else begin
               acc_in      = h_ff;
               acc_in.hole = 1'b0;
               acc_end_in  = h_end_ff;
            end
         end else begin
            acc_valid_in = 1'b0;
         end
      end

      if (emit_now) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (acc_ff.rtype == usable_type) begin
            total_in = total_ff + acc_ff.length;
            if (acc_end_ff > top_ff) begin
               top_in = acc_end_ff;
            end
         end
      end

      if (init) begin
         cnt_in   = '0;
         total_in = '0;
         top_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff        <= 1'b0;
         acc_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         total_ff     <= '0;
         top_ff       <= '0;
      end else begin
         hv_ff        <= hv_in;
         acc_valid_ff <= acc_valid_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         top_ff       <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff       <= h_in;
      h_end_ff   <= h_end_in;
      acc_ff     <= acc_in;
      acc_end_ff <= acc_end_in;
   end

   always_comb begin
      emit      = acc_ff;
      emit.hole = !emit_now;
   end

   assign merged_count = cnt_ff;
   assign total        = total_ff;
   assign top          = top_ff;

endmodule

// ----- hdl/memory_region_map_sanitizer.sv -----
// Memory region map sanitizer: collects, sorts and merges memory-map entries and answers queries.
//
// Input channel (req_*): one command per transfer (clear, load, build, query, read) with
// its operands. Result channel (rsp_*): exactly one result per accepted command. Both use
// valid/stall; an item moves on a clock edge with valid high and stall low.
// Configuration: csr_write_enable/csr_write_data set the usable type code (reset 1); write
// only while the block is idle.
// Entries live in a chain of MAX_ENTRIES cells. Clear, load, a failing build and an
// unknown command finish in the accept cycle; the result is valid the next cycle.
// Query and read rotate the chain once past the head, then load the result in state FIN.
// Build runs an odd-even transposition sort, streams the entries through the merge unit
// and re-sorts to close the gaps; its result is also loaded in state FIN.
// One command is in progress at a time; req_stall is high while one is. After a query, read
// or build the next command can be taken in the cycle the result appears, unless it is stalled.
// Reset (synchronous, active high) empties the map and zeroes counts and totals.
// A stalled result holds in the output register; a new command is taken once it drains.
module memory_region_map_sanitizer import mrms_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [31:0]         csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_command,
   input  logic [63:0]         req_entry_base,
   input  logic [63:0]         req_entry_length,
   input  logic [31:0]         req_entry_type,
   input  logic [63:0]         req_region_base,
   input  logic [63:0]         req_region_size,
   input  logic [INDEX_W-1:0]  req_entry_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_ok,
   output logic [7:0]          rsp_entry_count,
   output logic [63:0]         rsp_usable_total,
   output logic [63:0]         rsp_highest_usable,
   output logic                rsp_region_usable,
   output logic                rsp_index_valid,
   output logic [63:0]         rsp_out_base,
   output logic [63:0]         rsp_out_length,
   output logic [31:0]         rsp_out_type
);

   localparam int CMP_W = (STEP_W > INDEX_W) ? STEP_W : INDEX_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SORT1 = 3'd1;
   localparam logic [2:0] ST_MERGE = 3'd2;
   localparam logic [2:0] ST_SORT2 = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   raw_ff, raw_in;
   logic               ovf_ff, ovf_in;
   logic [63:0]        total_ff, total_in;
   logic [63:0]        top_ff, top_in;
   logic [31:0]        utype_ff, utype_in;
   logic [63:0]        qbase_ff, qbase_in;
   logic [63:0]        qend_ff, qend_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic               hit_ff, hit_in;
   entry_type          rd_ff, rd_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               load_store;
   logic               build_go;
   logic               rsp_load;
   rsp_type            resp;
   logic               sort_active;
   logic               last_round;
   logic               idx_ok;

   entry_type          ent [MAX_ENTRIES];
   cell_ctrl_type      ctrl [MAX_ENTRIES];
   logic               swap [MAX_ENTRIES-1];
   entry_type          ext_ent;
   entry_type          feed;
   entry_type          emit;
   logic [CNT_W-1:0]   m_count;
   logic [63:0]        m_total;
   logic [63:0]        m_top;

   assign req_stall   = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept      = req_valid && !req_stall;
   assign sort_active = (state_ff == ST_SORT1) || (state_ff == ST_SORT2);
   assign last_round  = (step_ff == STEP_W'(MAX_ENTRIES - 1));
   assign idx_ok      = CMP_W'(idx_ff) < CMP_W'(count_ff);

   assign ext_ent = '{hole: 1'b0, base: req_entry_base, length: req_entry_length,
                      rtype: req_entry_type};
   assign feed    = (state_ff == ST_MERGE) ? emit : ent[0];

   // compare-exchange keys: gaps sort behind real entries, ties keep their order
   for (genvar i = 0; i < MAX_ENTRIES - 1; i++) begin : g_swap
      assign swap[i] = {ent[i].hole, ent[i].base} > {ent[i+1].hole, ent[i+1].base};
   end

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      always_comb begin
         ctrl[i].sel       = SEL_HOLD;
         ctrl[i].mark      = build_go;
         ctrl[i].mark_hole = CNT_W'(i) >= count_ff;
         if (load_store && (CNT_W'(i) == count_ff)) begin
            ctrl[i].sel = SEL_EXT;
         end
         if (sort_active) begin
            if (i < MAX_ENTRIES - 1) begin
               if ((step_ff[0] == 1'(i % 2)) && swap[i]) begin
                  ctrl[i].sel = SEL_RIGHT;
               end
            end
            if (i > 0) begin
               if ((step_ff[0] == 1'((i - 1) % 2)) && swap[i-1]) begin
                  ctrl[i].sel = SEL_LEFT;
               end
            end
         end
         if ((state_ff == ST_MERGE) || (state_ff == ST_SCAN)) begin
            ctrl[i].sel = SEL_RIGHT;
         end
      end

      mrms_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl[i]),
         .left_in  ((i == 0) ? ent[0] : ent[(i == 0) ? 0 : i - 1]),
         .right_in ((i == MAX_ENTRIES - 1) ? feed : ent[(i == MAX_ENTRIES - 1) ? i : i + 1]),
         .ext_in   (ext_ent),
         .ent_out  (ent[i])
      );
   end

   mrms_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .run          (state_ff == ST_MERGE),
      .init         (build_go),
      .head_in      (ent[0]),
      .head_valid   (STEP_W'(count_ff) > step_ff),
      .usable_type  (utype_ff),
      .emit         (emit),
      .merged_count (m_count),
      .total        (m_total),
      .top          (m_top)
   );

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      raw_in     = raw_ff;
      ovf_in     = ovf_ff;
      total_in   = total_ff;
      top_in     = top_ff;
      qbase_in   = qbase_ff;
      qend_in    = qend_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      rd_in      = rd_ff;
      utype_in   = csr_write_enable ? csr_write_data : utype_ff;
      load_store = 1'b0;
      build_go   = 1'b0;
      rsp_load   = 1'b0;
      resp       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_command;
               step_in = '0;
               case (req_command)
                  CMD_CLEAR: begin
                     count_in = '0;
                     raw_in   = '0;
                     ovf_in   = 1'b0;
                     total_in = '0;
                     top_in   = '0;
                     resp.ok  = 1'b1;
                     rsp_load = 1'b1;
                  end
                  CMD_LOAD: begin
                     if (raw_ff >= CNT_W'(MAX_ENTRIES)) begin
                        ovf_in = 1'b1;
                     end else begin
                        raw_in  = raw_ff + CNT_W'(1);
                        resp.ok = 1'b1;
                        if ((req_entry_length != '0) && (count_ff < CNT_W'(MAX_ENTRIES))) begin
                           load_store = 1'b1;
                           count_in   = count_ff + CNT_W'(1);
                        end
                     end
                     rsp_load = 1'b1;
                  end
                  CMD_BUILD: begin
                     total_in = '0;
                     top_in   = '0;
                     if (ovf_ff || (count_ff == '0)) begin
                        count_in = '0;
                        rsp_load = 1'b1;
                     end else begin
                        build_go = 1'b1;
                        state_in = ST_SORT1;
                     end
                  end
                  CMD_QUERY: begin
                     qbase_in = req_region_base;
                     qend_in  = req_region_base + req_region_size;
                     hit_in   = 1'b0;
                     state_in = ST_SCAN;
                  end
                  CMD_READ: begin
                     idx_in   = req_entry_index;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SORT1: begin
            step_in = step_ff + STEP_W'(1);
            if (last_round) begin
               step_in  = '0;
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(count_ff) + STEP_W'(1)) begin
               step_in  = '0;
               state_in = ST_SORT2;
            end
         end
         ST_SORT2: begin
            step_in = step_ff + STEP_W'(1);
            if (last_round) begin
               count_in = m_count;
               total_in = m_total;
               top_in   = m_top;
               state_in = ST_FIN;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + STEP_W'(1);
            if ((STEP_W'(count_ff) > step_ff) && (ent[0].rtype == utype_ff)
                && (ent[0].base <= qbase_ff)
                && (qend_ff <= ent[0].base + ent[0].length)) begin
               hit_in = 1'b1;
            end
            if (CMP_W'(step_ff) == CMP_W'(idx_ff)) begin
               rd_in = ent[0];
            end
            if (last_round) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               case (cmd_ff)
                  CMD_QUERY: begin
                     resp.ok            = 1'b1;
                     resp.region_usable = hit_ff;
                  end
                  CMD_READ: begin
                     resp.ok          = idx_ok;
                     resp.index_valid = idx_ok;
                     if (idx_ok) begin
                        resp.out_base   = rd_ff.base;
                        resp.out_length = rd_ff.length;
                        resp.out_type   = rd_ff.rtype;
                     end
                  end
                  default: begin
                     resp.ok = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      resp.entry_count    = 8'(count_in);
      resp.usable_total   = total_in;
      resp.highest_usable = top_in;
      rsp_in              = rsp_load ? resp : rsp_ff;
      rsp_valid_in        = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cmd_ff       <= CMD_CLEAR;
         count_ff     <= '0;
         raw_ff       <= '0;
         ovf_ff       <= 1'b0;
         total_ff     <= '0;
         top_ff       <= '0;
         utype_ff     <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cmd_ff       <= cmd_in;
         count_ff     <= count_in;
         raw_ff       <= raw_in;
         ovf_ff       <= ovf_in;
         total_ff     <= total_in;
         top_ff       <= top_in;
         utype_ff     <= utype_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qbase_ff <= qbase_in;
      qend_ff  <= qend_in;
      idx_ff   <= idx_in;
      hit_ff   <= hit_in;
      rd_ff    <= rd_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ff.ok;
   assign rsp_entry_count    = rsp_ff.entry_count;
   assign rsp_usable_total   = rsp_ff.usable_total;
   assign rsp_highest_usable = rsp_ff.highest_usable;
   assign rsp_region_usable  = rsp_ff.region_usable;
   assign rsp_index_valid    = rsp_ff.index_valid;
   assign rsp_out_base       = rsp_ff.out_base;
   assign rsp_out_length     = rsp_ff.out_length;
   assign rsp_out_type       = rsp_ff.out_type;

endmodule

// ----- hdl/mrms_checker.sv -----
// Port-level checks for the memory region map sanitizer, bound to the top level.
module mrms_checker import mrms_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_ok,
   input logic [7:0]         rsp_entry_count,
   input logic [63:0]        rsp_usable_total,
   input logic [63:0]        rsp_highest_usable,
   input logic               rsp_region_usable,
   input logic               rsp_index_valid,
   input logic [63:0]        rsp_out_base,
   input logic [63:0]        rsp_out_length,
   input logic [31:0]        rsp_out_type
);

   // stalled result transfer keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_entry_count)
                                 && $stable(rsp_usable_total) && $stable(rsp_highest_usable)
                                 && $stable(rsp_region_usable) && $stable(rsp_index_valid)
                                 && $stable(rsp_out_base) && $stable(rsp_out_length)
                                 && $stable(rsp_out_type))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_index_valid || rsp_region_usable) |-> rsp_ok)
      else $error("hit or valid index reported without ok");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_index_valid |->
         (rsp_out_base == '0) && (rsp_out_length == '0) && (rsp_out_type == '0))
      else $error("entry data shown without a valid index");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (MAX_ENTRIES > 255) || (rsp_entry_count <= 8'(MAX_ENTRIES)))
      else $error("entry count beyond capacity");

endmodule

bind memory_region_map_sanitizer mrms_checker u_mrms_checker (.*);
